FILE: rtl/cfdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfdm_pkg: shared types and constants of the capture frequency/duty meter
// Holds field widths, register indexes, the divider operand codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cfdm_pkg;

  localparam int HZ_W    = 28;
  localparam int TPU_W   = 8;
  localparam int WUS_W   = 16;
  localparam int DUTY_W  = 7;
  localparam int PER_W   = 20;
  localparam int CAP_W   = 16;
  localparam int DIV_W   = 32;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int NUM_W   = WUS_W + DUTY_W;

  localparam logic [HZ_W-1:0]   COUNTER_HZ_RST   = 28'd100000000;
  localparam logic [TPU_W-1:0]  TICKS_PER_US_RST = 8'd100;
  localparam logic [PER_W-1:0]  US_PER_SEC       = 20'd1000000;
  localparam logic [DUTY_W-1:0] PCT_FULL         = 7'd100;
  localparam logic [WUS_W-1:0]  WIDTH_MAX        = 16'hFFFF;

  // register index = paddr[2]
  localparam logic REG_COUNTER_HZ   = 1'b0;
  localparam logic REG_TICKS_PER_US = 1'b1;

  localparam logic CHAN_PERIOD = 1'b0;
  localparam logic CHAN_WIDTH  = 1'b1;

  typedef enum logic [1:0] {
    SEL_FREQ,
    SEL_PERIOD,
    SEL_DUTY,
    SEL_WIDTH
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     decide;
    logic     freq_clear;
    logic     width_clear;
    logic     div_start;
    logic     div_load;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic chan;
    logic phase;
    logic ticks_ok;
    logic tpu_zero;
    logic freq_zero;
    logic width_zero;
    logic period_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/cfdm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfdm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. done pulses for one cycle
// with the quotient valid, once all DIV_W quotient bits are formed.
// ----------------------------------------------------------------------------
module cfdm_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cfdm_pkg::DIV_W-1:0] dividend,
  input  wire logic [cfdm_pkg::DIV_W-1:0] divisor,
  output logic                           done,
  output logic [cfdm_pkg::DIV_W-1:0]     quotient
);
  import cfdm_pkg::*;

  logic              active;
  logic [DCNT_W-1:0] step;
  logic [DIV_W:0]    part_rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] trial;

  assign shifted  = {part_rem[DIV_W-1:0], quo[DIV_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == DCNT_W'(DIV_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part_rem <= '0;
      quo      <= dividend;
      dvs      <= divisor;
    end else if (active) begin
      if (!trial[DIV_W]) begin
        part_rem <= trial;
        quo      <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        part_rem <= shifted;
        quo      <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cfdm_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfdm_regs: configuration registers on the APB-style port
// counter_hz at 0x0, ticks_per_us at 0x4. No wait states.
// ----------------------------------------------------------------------------
module cfdm_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [cfdm_pkg::HZ_W-1:0]       counter_hz,
  output logic [cfdm_pkg::TPU_W-1:0]      ticks_per_us
);
  import cfdm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_hz   <= COUNTER_HZ_RST;
      ticks_per_us <= TICKS_PER_US_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COUNTER_HZ:   counter_hz   <= pwdata[HZ_W-1:0];
        REG_TICKS_PER_US: ticks_per_us <= pwdata[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUNTER_HZ:   prdata = 32'(counter_hz);
      REG_TICKS_PER_US: prdata = 32'(ticks_per_us);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/cfdm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfdm_datapath: capture registers, measurement registers, shared divider
// Holds per-channel phase and start values, forms the tick count, feeds the
// divider and keeps the result register for the output channel.
// ----------------------------------------------------------------------------
module cfdm_datapath #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfdm_pkg::cmd_t                cmd,
  output cfdm_pkg::sts_t                     sts,
  input  wire logic                          channel,
  input  wire logic [cfdm_pkg::CAP_W-1:0]    capture_count,
  input  wire logic [cfdm_pkg::HZ_W-1:0]     counter_hz,
  input  wire logic [cfdm_pkg::TPU_W-1:0]    ticks_per_us,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [cfdm_pkg::HZ_W-1:0]          frequency_out,
  output logic [cfdm_pkg::WUS_W-1:0]         width_us_out,
  output logic [cfdm_pkg::DUTY_W-1:0]        duty_out,
  output logic                               period_done,
  output logic                               width_done
);
  import cfdm_pkg::*;

  logic                     chan_q;
  logic [COUNTER_WIDTH-1:0] cnt_q;
  logic                     period_phase;
  logic                     width_phase;
  logic [COUNTER_WIDTH-1:0] period_start;
  logic [COUNTER_WIDTH-1:0] width_start;
  logic                     is_end;
  logic [HZ_W-1:0]          frequency_reg;
  logic [WUS_W-1:0]         width_us_reg;
  logic [DUTY_W-1:0]        duty_reg;
  logic [PER_W-1:0]         cycle_us;

  logic [COUNTER_WIDTH-1:0] ticks;
  logic [NUM_W-1:0]         duty_num;
  logic [DIV_W-1:0]         div_a;
  logic [DIV_W-1:0]         div_b;
  logic [DIV_W-1:0]         div_q;
  logic                     div_done;

  assign ticks    = cnt_q - ((chan_q == CHAN_WIDTH) ? width_start : period_start);
  assign duty_num = NUM_W'(width_us_reg) * NUM_W'(PCT_FULL);

  always_comb begin
    unique case (cmd.div_sel)
      SEL_FREQ: begin
        div_a = DIV_W'(counter_hz);
        div_b = DIV_W'(ticks);
      end
      SEL_PERIOD: begin
        div_a = DIV_W'(US_PER_SEC);
        div_b = DIV_W'(frequency_reg);
      end
      SEL_DUTY: begin
        div_a = DIV_W'(duty_num);
        div_b = DIV_W'(cycle_us);
      end
      SEL_WIDTH: begin
        div_a = DIV_W'(ticks);
        div_b = DIV_W'(ticks_per_us);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  cfdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    sts.chan        = chan_q;
    sts.phase       = (chan_q == CHAN_WIDTH) ? width_phase : period_phase;
    sts.ticks_ok    = (ticks != '0) && (ticks != '1);
    sts.tpu_zero    = (ticks_per_us == '0);
    sts.freq_zero   = (frequency_reg == '0);
    sts.width_zero  = (width_us_reg == '0);
    sts.period_zero = (cycle_us == '0);
    sts.div_done    = div_done;
    sts.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chan_q <= channel;
      cnt_q  <= COUNTER_WIDTH'(capture_count);
    end
    if (cmd.div_load && cmd.div_sel == SEL_PERIOD) begin
      cycle_us <= div_q[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_phase  <= 1'b0;
      width_phase   <= 1'b0;
      period_start  <= '0;
      width_start   <= '0;
      is_end        <= 1'b0;
      frequency_reg <= '0;
      width_us_reg  <= '0;
      duty_reg      <= '0;
    end else begin
      if (cmd.decide) begin
        if (chan_q == CHAN_PERIOD) begin
          if (!period_phase) period_start <= cnt_q;
          period_phase <= !period_phase;
          is_end       <= period_phase;
        end else begin
          if (!width_phase) width_start <= cnt_q;
          width_phase <= !width_phase;
          is_end      <= width_phase;
        end
      end
      if (cmd.freq_clear)  frequency_reg <= '0;
      if (cmd.width_clear) width_us_reg  <= '0;
      if (cmd.div_load) begin
        unique case (cmd.div_sel)
          SEL_FREQ:   frequency_reg <= div_q[HZ_W-1:0];
          SEL_PERIOD: ;
          SEL_DUTY:   duty_reg <= (div_q > DIV_W'(PCT_FULL)) ? PCT_FULL : div_q[DUTY_W-1:0];
          SEL_WIDTH:  width_us_reg <= (div_q > DIV_W'(WIDTH_MAX)) ? WIDTH_MAX
                                                                  : div_q[WUS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result register: lets the next transfer in while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frequency_out <= frequency_reg;
      width_us_out  <= width_us_reg;
      duty_out      <= duty_reg;
      period_done   <= is_end && (chan_q == CHAN_PERIOD);
      width_done    <= is_end && (chan_q == CHAN_WIDTH);
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_reg <= PCT_FULL)
    else $error("duty register above full scale");

  a_freq_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_load && cmd.div_sel == SEL_FREQ) |-> (div_q <= DIV_W'(counter_hz)))
    else $error("frequency quotient exceeds counter_hz");

  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

FILE: rtl/cfdm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfdm_ctrl: sequencing of one capture event
// Decides start or end per channel, runs the divisions in order and loads
// the result register.
// ----------------------------------------------------------------------------
module cfdm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cfdm_pkg::sts_t sts,
  output cfdm_pkg::cmd_t      cmd
);
  import cfdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_FREQ,
    S_FREQ_WAIT,
    S_DUTY_CHECK,
    S_PERIOD,
    S_PERIOD_WAIT,
    S_PERIOD_CHECK,
    S_DUTY,
    S_DUTY_WAIT,
    S_WIDTH,
    S_WIDTH_WAIT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.div_sel    = SEL_FREQ;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!sts.phase) begin
          state_next = S_EMIT;
        end else if (sts.chan == CHAN_PERIOD) begin
          if (sts.ticks_ok) begin
            state_next = S_FREQ;
          end else begin
            cmd.freq_clear = 1'b1;
            state_next     = S_DUTY_CHECK;
          end
        end else if (sts.tpu_zero) begin
          cmd.width_clear = 1'b1;
          state_next      = S_EMIT;
        end else begin
          state_next = S_WIDTH;
        end
      end
      S_FREQ: begin
        cmd.div_sel   = SEL_FREQ;
        cmd.div_start = 1'b1;
        state_next    = S_FREQ_WAIT;
      end
      S_FREQ_WAIT: begin
        cmd.div_sel  = SEL_FREQ;
        cmd.div_load = sts.div_done;
        if (sts.div_done) state_next = S_DUTY_CHECK;
      end
      S_DUTY_CHECK: begin
        state_next = (sts.freq_zero || sts.width_zero) ? S_EMIT : S_PERIOD;
      end
      S_PERIOD: begin
        cmd.div_sel   = SEL_PERIOD;
        cmd.div_start = 1'b1;
        state_next    = S_PERIOD_WAIT;
      end
      S_PERIOD_WAIT: begin
        cmd.div_sel  = SEL_PERIOD;
        cmd.div_load = sts.div_done;
        if (sts.div_done) state_next = S_PERIOD_CHECK;
      end
      S_PERIOD_CHECK: begin
        // a period below one microsecond leaves the duty as it was
        state_next = sts.period_zero ? S_EMIT : S_DUTY;
      end
      S_DUTY: begin
        cmd.div_sel   = SEL_DUTY;
        cmd.div_start = 1'b1;
        state_next    = S_DUTY_WAIT;
      end
      S_DUTY_WAIT: begin
        cmd.div_sel  = SEL_DUTY;
        cmd.div_load = sts.div_done;
        if (sts.div_done) state_next = S_EMIT;
      end
      S_WIDTH: begin
        cmd.div_sel   = SEL_WIDTH;
        cmd.div_start = 1'b1;
        state_next    = S_WIDTH_WAIT;
      end
      S_WIDTH_WAIT: begin
        cmd.div_sel  = SEL_WIDTH;
        cmd.div_load = sts.div_done;
        if (sts.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_FREQ_WAIT || state == S_PERIOD_WAIT ||
                      state == S_DUTY_WAIT || state == S_WIDTH_WAIT))
    else $error("divider finished outside a wait state");

  a_capture_then_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_DECIDE))
    else $error("accepted transfer not decoded next cycle");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done right after start");

endmodule
`default_nettype wire

FILE: rtl/capture_frequency_duty_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// capture_frequency_duty_meter: input capture frequency and duty meter
// Pairs start/end captures per channel and reports frequency, pulse width
// and duty cycle after every capture event.
// ----------------------------------------------------------------------------
// One capture event is taken at a time and gives one result. All divisions
// run on a single shared 32-step restoring divider. A start capture goes
// straight to the result load; a width end runs the width division (none
// with ticks_per_us at 0); a period end runs the frequency division when
// the tick count is in range and then the period and duty divisions when
// their operands allow. The next input transfer is taken once the current
// result is in the output register, even if that result has not been
// transferred out yet. counter_hz sits at byte address 0x0 and
// ticks_per_us at 0x4; write them only while no event is in flight.
module capture_frequency_duty_meter #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       channel,
  input  wire logic [cfdm_pkg::CAP_W-1:0] capture_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [cfdm_pkg::HZ_W-1:0]       frequency_out,
  output logic [cfdm_pkg::WUS_W-1:0]      width_us_out,
  output logic [cfdm_pkg::DUTY_W-1:0]     duty_out,
  output logic                            period_done,
  output logic                            width_done
);
  import cfdm_pkg::*;

  logic [HZ_W-1:0]  counter_hz;
  logic [TPU_W-1:0] ticks_per_us;
  cmd_t             cmd;
  sts_t             sts;

  cfdm_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .counter_hz   (counter_hz),
    .ticks_per_us (ticks_per_us)
  );

  cfdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfdm_datapath #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .channel       (channel),
    .capture_count (capture_count),
    .counter_hz    (counter_hz),
    .ticks_per_us  (ticks_per_us),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .frequency_out (frequency_out),
    .width_us_out  (width_us_out),
    .duty_out      (duty_out),
    .period_done   (period_done),
    .width_done    (width_done)
  );

endmodule
`default_nettype wire
